// ----- rtl/sbo_pkg.sv -----
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared widths, types and register codes of the segment/box overlap test.
// ----------------------------------------------------------------------------
package sbo_pkg;

   localparam int W     = 32;        // coordinate width, signed Q16.16
   localparam int DW    = W + 1;     // endpoint differences
   localparam int XW    = W + 2;     // offsets from widened bounds, magnitudes
   localparam int PW    = 2 * W + 4; // products
   localparam int SW    = PW + 1;    // product sums
   localparam int NFACE = 6;
   localparam int TOL   = 7;         // 0.0001 in Q16.16
   localparam int CAW   = 3;         // csr index width
   localparam int REQW  = 6 * W;
   localparam int RSPW  = 8;

   typedef logic signed [W-1:0]  coord_type;
   typedef logic signed [DW-1:0] dif_type;
   typedef logic signed [XW-1:0] ext_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef enum logic [CAW-1:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } csr_reg_type;

   // a word after the plane setup: one face per axis end
   typedef struct {
      logic    miss;
      logic    enclosed;
      dif_type d   [3];
      ext_type rlo [3];
      ext_type rhi [3];
      ext_type den [NFACE];
      ext_type nn  [NFACE];
      logic    fv  [NFACE];
   } face_type;

   // a word after the multipliers
   typedef struct {
      logic     miss;
      logic     enclosed;
      logic     fv    [NFACE];
      prod_type along [NFACE][3];
      prod_type plo   [NFACE][3];
      prod_type phi   [NFACE][3];
   } prod_set_type;

endpackage

// ----- rtl/segment_box_overlap_test.sv -----
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Segment versus axis-aligned box hit test, pipelined, one segment a cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// req channel: one word per segment, both endpoints, signed Q16.16.
// rsp channel: one word per segment, in order, bit 0 is the hit flag.
// csr channel: writes a box bound; index 0..2 minimum x/y/z, 3..5 maximum
//    x/y/z, other indexes are dropped. Always ready; write only while idle.
// The req word passes through five register stages: two setup stages, the
// multiplier stage, the compare stage and the output register.
// Throughput is one segment per cycle unless the receiver stalls; the
// multiplier bank (54 products of about 34 by 34 bits) sets the depth of
// the third stage.
// Reset clears all valid bits and sets the box to all zeros.
// When the receiver stalls each stage holds its word and the ready signal
// ripples back, so req_tready falls only once every stage is full.
// ----------------------------------------------------------------------------
module segment_box_overlap_test
   import sbo_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [REQW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // hit, then zero fill
   output logic [RSPW-1:0] rsp_tdata,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CAW-1:0]  csr_addr,
   input  logic [W-1:0]    csr_data
);

   coord_type    box_min_ff [3];
   coord_type    box_max_ff [3];
   coord_type    s [3], e [3];
   face_type     face_word;
   prod_set_type prod_word;
   logic         prep_valid, prep_ready, mul_valid, mul_ready;
   logic         judge_valid, judge_ready, judge_hit;
   logic         rsp_v_ff, rsp_hit_ff, rsp_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_min_ff[k] <= '0;
            box_max_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_addr))
            REG_MIN_X: box_min_ff[0] <= csr_data;
            REG_MIN_Y: box_min_ff[1] <= csr_data;
            REG_MIN_Z: box_min_ff[2] <= csr_data;
            REG_MAX_X: box_max_ff[0] <= csr_data;
            REG_MAX_Y: box_max_ff[1] <= csr_data;
            REG_MAX_Z: box_max_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s[k] = req_tdata[k*W +: W];
         e[k] = req_tdata[(k+3)*W +: W];
      end
   end

   sbo_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .s         (s),
      .e         (e),
      .box_min   (box_min_ff),
      .box_max   (box_max_ff),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_word  (face_word)
   );

   sbo_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_word   (face_word),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_word  (prod_word)
   );

   sbo_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_word   (prod_word),
      .out_valid (judge_valid),
      .out_ready (judge_ready),
      .out_hit   (judge_hit)
   );

   assign rsp_en      = !rsp_v_ff || rsp_tready;
   assign judge_ready = rsp_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_v_ff <= judge_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_en) begin
         rsp_hit_ff <= judge_hit;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(RSPW-1){1'b0}}, rsp_hit_ff};

endmodule

// ----- rtl/sbo_prep.sv -----
// ----------------------------------------------------------------------------
// sbo_prep
// Two stages: endpoint differences, early reject and inside tests, then the
// sign-normalised plane distances and denominators of the six faces.
// ----------------------------------------------------------------------------
module sbo_prep
   import sbo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  coord_type s [3],
   input  coord_type e [3],
   input  coord_type box_min [3],
   input  coord_type box_max [3],
   output logic      out_valid,
   input  logic      out_ready,
   output face_type  out_word
);

   logic    va_ff, vb_ff;
   logic    ena, enb;
   logic    miss_in, inside_in, miss_a_ff, inside_a_ff;
   dif_type d_in [3], d_a_ff [3];
   ext_type rlo_in [3], rhi_in [3], rlo_a_ff [3], rhi_a_ff [3];
   dif_type n_in [NFACE], n_a_ff [NFACE];
   face_type b_in, b_ff;

   assign enb      = !vb_ff || out_ready;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   always_comb begin
      miss_in   = 1'b0;
      inside_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         d_in[k]   = DW'(e[k]) - DW'(s[k]);
         rlo_in[k] = XW'(s[k]) - (XW'(box_min[k]) - XW'(TOL));
         rhi_in[k] = XW'(s[k]) - (XW'(box_max[k]) + XW'(TOL));
         if ((s[k] < box_min[k] && e[k] < box_min[k]) ||
             (s[k] > box_max[k] && e[k] > box_max[k])) begin
            miss_in = 1'b1;
         end
         if (s[k] < box_min[k] || s[k] > box_max[k]) begin
            inside_in = 1'b0;
         end
      end
      // the end point may be inside instead
      if (!inside_in) begin
         inside_in = 1'b1;
         for (int k = 0; k < 3; k++) begin
            if (e[k] < box_min[k] || e[k] > box_max[k]) begin
               inside_in = 1'b0;
            end
         end
      end
      for (int f = 0; f < NFACE; f++) begin
         // even faces at the maximum, odd at the minimum
         n_in[f] = f[0] ? DW'(box_min[f/2]) - DW'(s[f/2])
                        : DW'(box_max[f/2]) - DW'(s[f/2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         miss_a_ff   <= miss_in;
         inside_a_ff <= inside_in;
         d_a_ff      <= d_in;
         rlo_a_ff    <= rlo_in;
         rhi_a_ff    <= rhi_in;
         n_a_ff      <= n_in;
      end
   end

   always_comb begin
      b_in.miss     = miss_a_ff;
      b_in.enclosed = inside_a_ff;
      b_in.d        = d_a_ff;
      b_in.rlo      = rlo_a_ff;
      b_in.rhi      = rhi_a_ff;
      for (int f = 0; f < NFACE; f++) begin
         b_in.fv[f] = (d_a_ff[f/2] != '0);
         if (d_a_ff[f/2] < 0) begin
            b_in.den[f] = -XW'(d_a_ff[f/2]);
            b_in.nn[f]  = -XW'(n_a_ff[f]);
         end else begin
            b_in.den[f] = XW'(d_a_ff[f/2]);
            b_in.nn[f]  = XW'(n_a_ff[f]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enb) begin
         b_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= in_valid;
         if (enb) vb_ff <= va_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_word  = b_ff;

endmodule

// ----- rtl/sbo_mul.sv -----
// ----------------------------------------------------------------------------
// sbo_mul
// Multiplier stage: scaled bound offsets and the line term for every face
// and axis, each product registered.
// ----------------------------------------------------------------------------
module sbo_mul
   import sbo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  face_type     in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output prod_set_type out_word
);

   logic         v_ff, en;
   prod_set_type p_in, p_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      p_in.miss     = in_word.miss;
      p_in.enclosed = in_word.enclosed;
      p_in.fv       = in_word.fv;
      for (int f = 0; f < NFACE; f++) begin
         for (int k = 0; k < 3; k++) begin
            p_in.along[f][k] = PW'(in_word.d[k]) * PW'(in_word.nn[f]);
            p_in.plo[f][k]   = PW'(in_word.rlo[k]) * PW'(in_word.den[f]);
            p_in.phi[f][k]   = PW'(in_word.rhi[k]) * PW'(in_word.den[f]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = p_ff;

endmodule

// ----- rtl/sbo_judge.sv -----
// ----------------------------------------------------------------------------
// sbo_judge
// Sums the products, checks every cut point against the widened box and
// forms the hit bit.
// ----------------------------------------------------------------------------
module sbo_judge
   import sbo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  prod_set_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output logic         out_hit
);

   logic    v_ff, en;
   logic    hit_in, hit_ff, miss_ff, inside_ff;
   logic    face_ok;
   sum_type slo, shi;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      hit_in = in_word.enclosed;
      for (int f = 0; f < NFACE; f++) begin
         face_ok = in_word.fv[f];
         for (int k = 0; k < 3; k++) begin
            slo = SW'(in_word.plo[f][k]) + SW'(in_word.along[f][k]);
            shi = SW'(in_word.phi[f][k]) + SW'(in_word.along[f][k]);
            if (slo < 0 || shi > 0) begin
               face_ok = 1'b0;
            end
         end
         if (face_ok) begin
            hit_in = 1'b1;
         end
      end
      if (in_word.miss) begin
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff    <= hit_in;
         miss_ff   <= in_word.miss;
         inside_ff <= in_word.enclosed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   assign out_valid = v_ff;
   assign out_hit   = hit_ff;

`ifndef SYNTHESIS
   a_miss_clear : assert property (@(posedge clock) disable iff (reset)
      v_ff && miss_ff |-> !hit_ff)
      else $error("rejected segment reported as hit");
   a_inside_hit : assert property (@(posedge clock) disable iff (reset)
      v_ff && inside_ff && !miss_ff |-> hit_ff)
      else $error("endpoint inside box but no hit");
   a_hold : assert property (@(posedge clock) disable iff (reset)
      v_ff && !out_ready |=> v_ff && $stable(hit_ff))
      else $error("stalled result changed");
`endif

endmodule

// ----- sim/tb_segment_box_overlap_test.sv -----
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test
// Self-checking bench for the segment/box overlap test: segments are streamed
// in against several box settings, each hit flag is predicted with exact wide
// integer arithmetic and compared in order with the block's responses.
// ----------------------------------------------------------------------------
module tb_segment_box_overlap_test
   import sbo_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LIMIT = 400000;
   localparam int  SLACK = 20;
   localparam int  LONG_STALL = 60;

   typedef struct {
      coord_type s [3];
      coord_type e [3];
   } seg_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [REQW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RSPW-1:0] rsp_tdata;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [CAW-1:0]  csr_addr = '0;
   logic [W-1:0]    csr_data = '0;

   segment_box_overlap_test dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   coord_type bmin [3];
   coord_type bmax [3];
   seg_type   pending_segs [$];
   logic      expected_hits [$];
   int        errors = 0;
   int        cycles = 0;
   int        hold_off = 0;
   int        req_wait = 0;
   int        rsp_wait = 0;
   bit        req_acc = 1'b0;
   bit        rsp_acc = 1'b0;

   // (p - lim) * den + along, all exact; the callers test its sign
   function automatic logic signed [127:0] cut_sum(longint p, longint lim, longint den,
                                                   logic signed [127:0] along);
      logic signed [127:0] a;
      a = p - lim;
      return a * den + along;
   endfunction

   function automatic bit face_cut(longint p [3], longint d [3], int a, longint pl);
      longint n, den, lo, hi;
      logic signed [127:0] along, slo, shi, dk;
      if (d[a] == 0) return 1'b0;
      n = pl - p[a];
      den = d[a];
      if (den < 0) begin
         n = -n;
         den = -den;
      end
      for (int k = 0; k < 3; k++) begin
         lo = longint'(bmin[k]) - TOL;
         hi = longint'(bmax[k]) + TOL;
         dk = d[k];
         along = dk * n;
         slo = cut_sum(p[k], lo, den, along);
         shi = cut_sum(p[k], hi, den, along);
         if (slo < 0) return 1'b0;
         if (shi > 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit in_box(longint q [3]);
      for (int k = 0; k < 3; k++)
         if (q[k] < bmin[k] || q[k] > bmax[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic predict_hit(seg_type g);
      longint s [3], e [3], d [3];
      for (int k = 0; k < 3; k++) begin
         s[k] = g.s[k];
         e[k] = g.e[k];
         d[k] = e[k] - s[k];
      end
      for (int k = 0; k < 3; k++)
         if ((s[k] < bmin[k] && e[k] < bmin[k]) || (s[k] > bmax[k] && e[k] > bmax[k]))
            return 1'b0;
      if (in_box(s) || in_box(e)) return 1'b1;
      for (int k = 0; k < 3; k++)
         if (face_cut(s, d, k, bmax[k]) || face_cut(s, d, k, bmin[k])) return 1'b1;
      return 1'b0;
   endfunction

   // driver: one segment word per handshake, a drawn gap after each word
   always @(negedge clock) begin
      seg_type g;
      if (!reset) begin
         if (req_tvalid && !req_acc) begin
            // hold the word
         end else if (req_wait > 0) begin
            req_wait <= req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (pending_segs.size() > 0) begin
            g = pending_segs[0];
            req_tdata <= {g.e[2], g.e[1], g.e[0], g.s[2], g.s[1], g.s[0]};
            req_tvalid <= 1'b1;
            req_wait <= $urandom_range(0, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver readiness: a drawn wait after each word, one long hold-off on request
   always @(negedge clock) begin
      int gap;
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_acc) begin
            gap = $urandom_range(0, 8);
            rsp_wait <= gap;
            rsp_tready <= (gap == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_tready <= (rsp_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // predictions taken at the input handshake
   always @(posedge clock) begin
      req_acc <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_hits.push_back(predict_hit(pending_segs[0]));
         void'(pending_segs.pop_front());
      end
   end

   // monitor
   always @(posedge clock) begin
      logic want;
      cycles <= cycles + 1;
      rsp_acc <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected response word, hit=%0d", rsp_tdata[0]);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("hit mismatch: expected %0d, actual %0d", want, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[RSPW-1:1] !== '0) begin
               $error("fill mismatch: expected 0, actual %0h", rsp_tdata[RSPW-1:1]);
               errors++;
            end
         end
      end
      if (cycles >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(csr_reg_type idx, coord_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx <= REG_MIN_Z) bmin[idx] = val;
      else bmax[idx - REG_MAX_X] = val;
   endtask

   task automatic set_box(coord_type x0, coord_type y0, coord_type z0,
                          coord_type x1, coord_type y1, coord_type z1);
      write_reg(REG_MIN_X, x0);
      write_reg(REG_MIN_Y, y0);
      write_reg(REG_MIN_Z, z0);
      write_reg(REG_MAX_X, x1);
      write_reg(REG_MAX_Y, y1);
      write_reg(REG_MAX_Z, z1);
   endtask

   task automatic drain;
      while (pending_segs.size() > 0 || expected_hits.size() > 0) @(posedge clock);
      repeat (SLACK) @(posedge clock);
   endtask

   function automatic coord_type near_coord(int axis, bit mx);
      coord_type c;
      int r;
      r = $urandom_range(0, 9);
      c = mx ? bmax[axis] : bmin[axis];
      if (r < 3) return c + $signed($urandom_range(0, 20)) - 10;
      if (r < 8) return coord_type'(longint'(bmin[axis]) +
                    (longint'($urandom) % (longint'(bmax[axis]) - bmin[axis] + 1 + 64)) - 32);
      return coord_type'($urandom);
   endfunction

   task automatic queue_seg(coord_type sx, coord_type sy, coord_type sz,
                            coord_type ex, coord_type ey, coord_type ez);
      seg_type g;
      g.s = '{sx, sy, sz};
      g.e = '{ex, ey, ez};
      pending_segs.push_back(g);
   endtask

   task automatic queue_random(int count);
      seg_type g;
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               g.s[k] = coord_type'($urandom);
               g.e[k] = coord_type'($urandom);
            end else begin
               g.s[k] = near_coord(k, $urandom_range(0, 1));
               g.e[k] = near_coord(k, $urandom_range(0, 1));
            end
         end
         if ($urandom_range(0, 15) == 0) g.e = g.s;
         pending_segs.push_back(g);
      end
   endtask

   localparam coord_type ONE = 32'sh0001_0000;
   localparam coord_type CMIN = 32'sh8000_0000;
   localparam coord_type CMAX = 32'sh7fff_ffff;

   initial begin
      bmin = '{0, 0, 0};
      bmax = '{0, 0, 0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unit box
      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      queue_seg(0, 0, 0, 0, 0, 0);                              // point inside
      queue_seg(3*ONE, 0, 0, 3*ONE, 0, 0);                      // point outside
      queue_seg(-ONE, -ONE, -ONE, 5*ONE, 5*ONE, 5*ONE);         // endpoint on corner
      queue_seg(-3*ONE, 0, 0, 3*ONE, 0, 0);                     // crossing x
      queue_seg(0, -3*ONE, 0, 0, 3*ONE, 0);                     // crossing y
      queue_seg(0, 0, -3*ONE, 0, 0, 3*ONE);                     // crossing z
      queue_seg(-5*ONE, 0, 0, -3*ONE, 0, 0);                    // both below x
      queue_seg(2*ONE, 3*ONE, 0, 3*ONE, 2*ONE, 0);              // both beyond x maximum
      queue_seg(-3*ONE, ONE + 7, 0, 3*ONE, ONE + 7, 0);         // within tolerance
      queue_seg(-3*ONE, ONE + 8, 0, 3*ONE, ONE + 8, 0);         // just past tolerance
      queue_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);            // extreme diagonal
      queue_seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
      queue_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      queue_seg(-3*ONE, 2*ONE, 0, 3*ONE, -2*ONE, 5);            // skew crossing
      drain();

      // long receiver hold-off while the sender keeps offering
      queue_random(40);
      hold_off = LONG_STALL;
      drain();
      queue_random(200);
      drain();

      // inverted box
      set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
      queue_seg(0, 0, 0, 0, 0, 0);
      queue_seg(-3*ONE, 0, 0, 3*ONE, 0, 0);
      queue_random(60);
      drain();

      // full-range box
      set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
      queue_seg(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
      queue_random(40);
      drain();

      // random boxes
      for (int b = 0; b < 4; b++) begin
         coord_type lo [3], hi [3];
         for (int k = 0; k < 3; k++) begin
            lo[k] = coord_type'($urandom) >>> $urandom_range(0, 16);
            hi[k] = lo[k] + ($urandom >> $urandom_range(2, 24));
            if ($urandom_range(0, 7) == 0) hi[k] = coord_type'($urandom);
         end
         set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         queue_random(55);
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sbo_pkg.sv
rtl/sbo_prep.sv
rtl/sbo_mul.sv
rtl/sbo_judge.sv
rtl/segment_box_overlap_test.sv
sim/tb_segment_box_overlap_test.sv
